// File: hdl/cbcr_pkg.sv
// shared types, constants and cell functions for the circle-box collision block
`timescale 1ns / 1ps
package cbcr_pkg;

    localparam int COORD_BITS = 16;
    localparam int RAD_BITS   = 14;
    localparam int GAIN_BITS  = 9;
    localparam int GAIN_SHIFT = 8;
    localparam int CFG_BITS   = 14;
    localparam int IDX_BITS   = 2;
    // distances below the radius fit in radius bits
    localparam int ROOT_BITS  = RAD_BITS;
    localparam int SQ_BITS    = 2 * RAD_BITS + 1;
    // quotient of |d| * ovl / dist is at most ovl
    localparam int QUO_BITS   = RAD_BITS;
    localparam int NUM_BITS   = 2 * RAD_BITS;
    localparam int WIDE_BITS  = COORD_BITS + 3;
    // bit position handed to each root or divider cell
    localparam int POS_BITS   = 4;

    typedef enum logic [IDX_BITS-1:0] {
        REG_RADIUS = 2'd0,
        REG_WIDTH  = 2'd1,
        REG_HEIGHT = 2'd2,
        REG_GAIN   = 2'd3
    } reg_idx_t;

    // work item carried from cell to cell
    typedef struct packed {
        logic                          vld;
        logic                          hit;
        logic                          in_box;
        logic signed [COORD_BITS-1:0]  bx;
        logic signed [COORD_BITS-1:0]  by;
        logic signed [COORD_BITS-1:0]  vx;
        logic                          sx;
        logic                          sy;
        logic [RAD_BITS-1:0]           adx;
        logic [RAD_BITS-1:0]           ady;
        logic [RAD_BITS-1:0]           rad;
        logic [SQ_BITS-1:0]            rem;
        logic [ROOT_BITS-1:0]          root;
        logic [NUM_BITS-1:0]           numx;
        logic [NUM_BITS-1:0]           numy;
        logic [QUO_BITS-1:0]           qx;
        logic [QUO_BITS-1:0]           qy;
        logic signed [COORD_BITS-1:0]  nv;
    } cbcr_item_t;

    function automatic logic signed [COORD_BITS-1:0] sat_coord(
        input logic signed [WIDE_BITS-1:0] v);
        logic signed [WIDE_BITS-1:0] hi;
        logic signed [WIDE_BITS-1:0] lo;
        hi = WIDE_BITS'((1 <<< (COORD_BITS - 1)) - 1);
        lo = -hi - WIDE_BITS'(1);
        if (v > hi)
            return hi[COORD_BITS-1:0];
        else if (v < lo)
            return lo[COORD_BITS-1:0];
        return v[COORD_BITS-1:0];
    endfunction

endpackage

// File: hdl/cbcr_root_cell.sv
// one restoring square-root cell: settles one root bit per cycle while en is high
`timescale 1ns / 1ps
module cbcr_root_cell
    import cbcr_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  logic [POS_BITS-1:0] bit_pos,
    input  cbcr_item_t          din,
    output cbcr_item_t          dout
);

    cbcr_item_t dout_reg;
    cbcr_item_t dout_next;
    logic [SQ_BITS+1:0] trial;

    // trial root with this bit set, compare its square against the sum
    always_comb
    begin
        dout_next = din;
        trial = (SQ_BITS+2)'(din.root | (ROOT_BITS'(1) << bit_pos));
        if (trial * trial <= (SQ_BITS+2)'(din.rem))
            dout_next.root = trial[ROOT_BITS-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            dout_reg.vld <= 1'b0;
        else if (en)
            dout_reg <= dout_next;
    end

    assign dout = dout_reg;

endmodule

// File: hdl/cbcr_div_cell.sv
// one restoring divider cell: settles one quotient bit of both push terms
`timescale 1ns / 1ps
module cbcr_div_cell
    import cbcr_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  logic [POS_BITS-1:0] bit_pos,
    input  cbcr_item_t          din,
    output cbcr_item_t          dout
);

    cbcr_item_t dout_reg;
    cbcr_item_t dout_next;
    logic [NUM_BITS+QUO_BITS-1:0] dsh;

    // subtract the shifted divisor where it fits
    always_comb
    begin
        dout_next = din;
        dsh = (NUM_BITS+QUO_BITS)'(din.root) << bit_pos;
        if ((NUM_BITS+QUO_BITS)'(din.numx) >= dsh && din.root != '0)
        begin
            dout_next.numx = din.numx - dsh[NUM_BITS-1:0];
            dout_next.qx   = din.qx | (QUO_BITS'(1) << bit_pos);
        end
        if ((NUM_BITS+QUO_BITS)'(din.numy) >= dsh && din.root != '0)
        begin
            dout_next.numy = din.numy - dsh[NUM_BITS-1:0];
            dout_next.qy   = din.qy | (QUO_BITS'(1) << bit_pos);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            dout_reg.vld <= 1'b0;
        else if (en)
            dout_reg <= dout_next;
    end

    assign dout = dout_reg;

endmodule

// File: hdl/circle_box_collision_response.sv
// top level: front cells, root cell chain, overlap cell, divider cell chain, output
`timescale 1ns / 1ps
// Circle versus axis-aligned box collision response, signed Q12.4.
// Input channel: in_valid/in_ready carry ball_x, ball_y, ball_vx, box_cx,
// box_cy; a transfer happens when both are high. Output channel:
// out_valid/out_ready carry hit, new_x, new_y, new_vx, one result per input.
// The registers ball_radius, box_width, box_height and bounce_gain are
// written through cfg_we/cfg_idx/cfg_data; the user must write them only
// while the block is idle, which the block itself does not enforce. Work
// flows through a row of cells: two front cells (clamp, squares and speed
// gain), one cell per root bit (14), one overlap cell, one cell per quotient
// bit (14) and a final cell that applies the push and saturates. One item
// is taken per cycle while the receiver does not stall. The whole row
// advances together, so when the receiver stalls with a result waiting the
// row holds and in_ready drops; the row moves again in the cycle the result
// is taken. Reset clears all valid bits and loads the register reset values.
module circle_box_collision_response
    import cbcr_pkg::*;
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic signed [COORD_BITS-1:0]  ball_x,
    input  logic signed [COORD_BITS-1:0]  ball_y,
    input  logic signed [COORD_BITS-1:0]  ball_vx,
    input  logic signed [COORD_BITS-1:0]  box_cx,
    input  logic signed [COORD_BITS-1:0]  box_cy,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic                          hit,
    output logic signed [COORD_BITS-1:0]  new_x,
    output logic signed [COORD_BITS-1:0]  new_y,
    output logic signed [COORD_BITS-1:0]  new_vx,
    input  logic                          cfg_we,
    input  logic [IDX_BITS-1:0]           cfg_idx,
    input  logic [CFG_BITS-1:0]           cfg_data
);

    logic [RAD_BITS-1:0]  radius_reg;
    logic [RAD_BITS-1:0]  width_reg;
    logic [RAD_BITS-1:0]  height_reg;
    logic [GAIN_BITS-1:0] gain_reg;
    logic                 en;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg <= RAD_BITS'(320);
            width_reg  <= RAD_BITS'(480);
            height_reg <= RAD_BITS'(2400);
            gain_reg   <= GAIN_BITS'(269);
        end
        else if (cfg_we)
        begin
            case (reg_idx_t'(cfg_idx))
                REG_RADIUS: radius_reg <= cfg_data;
                REG_WIDTH:  width_reg  <= cfg_data;
                REG_HEIGHT: height_reg <= cfg_data;
                REG_GAIN:   gain_reg   <= cfg_data[GAIN_BITS-1:0];
                default:    ;
            endcase
        end
    end

    cbcr_item_t out_reg;
    assign en       = !out_reg.vld || out_ready;
    assign in_ready = en;

    // front cell: clamp to box, axis distances, speed magnitude times gain
    cbcr_item_t f1_reg;
    cbcr_item_t f1_next;
    logic signed [WIDE_BITS-1:0] left, right, top, bot, dxw, dyw;
    logic [COORD_BITS-1:0] avx;
    logic [COORD_BITS+GAIN_BITS-1:0] vprod;
    logic [COORD_BITS:0] vmag;
    logic signed [WIDE_BITS-1:0] nvw;
    always_comb
    begin
        f1_next = '0;
        left  = WIDE_BITS'(box_cx) - WIDE_BITS'(width_reg >> 1);
        right = left + WIDE_BITS'(width_reg);
        top   = WIDE_BITS'(box_cy) - WIDE_BITS'(height_reg >> 1);
        bot   = top + WIDE_BITS'(height_reg);
        if (WIDE_BITS'(ball_x) < left)
            dxw = WIDE_BITS'(ball_x) - left;
        else if (WIDE_BITS'(ball_x) > right)
            dxw = WIDE_BITS'(ball_x) - right;
        else
            dxw = '0;
        if (WIDE_BITS'(ball_y) < top)
            dyw = WIDE_BITS'(ball_y) - top;
        else if (WIDE_BITS'(ball_y) > bot)
            dyw = WIDE_BITS'(ball_y) - bot;
        else
            dyw = '0;
        avx   = ball_vx < 0 ? COORD_BITS'(-ball_vx) : COORD_BITS'(ball_vx);
        vprod = (COORD_BITS+GAIN_BITS)'(avx) * (COORD_BITS+GAIN_BITS)'(gain_reg);
        vmag  = (COORD_BITS+1)'(vprod >> GAIN_SHIFT);
        nvw   = ball_vx > 0 ? -WIDE_BITS'(vmag) : WIDE_BITS'(vmag);
        f1_next.vld = in_valid;
        f1_next.bx  = ball_x;
        f1_next.by  = ball_y;
        f1_next.vx  = ball_vx;
        f1_next.sx  = dxw < 0;
        f1_next.sy  = dyw < 0;
        f1_next.rad = radius_reg;
        f1_next.nv  = sat_coord(nvw);
        // any axis distance at or past the radius is a miss
        f1_next.hit = ((dxw < 0 ? -dxw : dxw) < WIDE_BITS'(radius_reg))
                   && ((dyw < 0 ? -dyw : dyw) < WIDE_BITS'(radius_reg));
        f1_next.adx = f1_next.hit ? RAD_BITS'(dxw < 0 ? -dxw : dxw) : '0;
        f1_next.ady = f1_next.hit ? RAD_BITS'(dyw < 0 ? -dyw : dyw) : '0;
    end

    // second front cell: squared distance against squared radius
    cbcr_item_t f2_reg;
    cbcr_item_t f2_next;
    logic [SQ_BITS-1:0] dsq;
    always_comb
    begin
        f2_next = f1_reg;
        dsq = SQ_BITS'(f1_reg.adx) * SQ_BITS'(f1_reg.adx)
            + SQ_BITS'(f1_reg.ady) * SQ_BITS'(f1_reg.ady);
        f2_next.rem    = dsq;
        f2_next.root   = '0;
        f2_next.hit    = f1_reg.hit
                      && dsq < SQ_BITS'(f1_reg.rad) * SQ_BITS'(f1_reg.rad);
        f2_next.in_box = dsq == '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f1_reg.vld <= 1'b0;
            f2_reg.vld <= 1'b0;
        end
        else if (en)
        begin
            f1_reg <= f1_next;
            f2_reg <= f2_next;
        end
    end

    // root cell chain, most significant bit first
    cbcr_item_t rt [ROOT_BITS+1];
    assign rt[0] = f2_reg;
    for (genvar i = 0; i < ROOT_BITS; i++)
    begin : g_root
        cbcr_root_cell u_cell (
            .clk    (clk),
            .rst_n  (rst_n),
            .en     (en),
            .bit_pos(POS_BITS'(ROOT_BITS - 1 - i)),
            .din    (rt[i]),
            .dout   (rt[i+1])
        );
    end

    // overlap cell: numerators |d| * (r - dist)
    cbcr_item_t ov_reg;
    cbcr_item_t ov_next;
    logic [RAD_BITS-1:0] ovl;
    always_comb
    begin
        ov_next = rt[ROOT_BITS];
        ovl = rt[ROOT_BITS].rad - rt[ROOT_BITS].root;
        ov_next.numx = NUM_BITS'(rt[ROOT_BITS].adx) * NUM_BITS'(ovl);
        ov_next.numy = NUM_BITS'(rt[ROOT_BITS].ady) * NUM_BITS'(ovl);
        ov_next.qx   = '0;
        ov_next.qy   = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ov_reg.vld <= 1'b0;
        else if (en)
            ov_reg <= ov_next;
    end

    // divider cell chain
    cbcr_item_t dv [QUO_BITS+1];
    assign dv[0] = ov_reg;
    for (genvar i = 0; i < QUO_BITS; i++)
    begin : g_div
        cbcr_div_cell u_cell (
            .clk    (clk),
            .rst_n  (rst_n),
            .en     (en),
            .bit_pos(POS_BITS'(QUO_BITS - 1 - i)),
            .din    (dv[i]),
            .dout   (dv[i+1])
        );
    end

    // final cell: apply push or inside-box shove, saturate
    cbcr_item_t out_next;
    cbcr_item_t dl;
    logic signed [WIDE_BITS-1:0] nxw, nyw;
    always_comb
    begin
        dl = dv[QUO_BITS];
        out_next = dl;
        nxw = WIDE_BITS'(dl.bx);
        nyw = WIDE_BITS'(dl.by);
        if (dl.hit && dl.in_box)
            nxw = dl.vx > 0 ? nxw - WIDE_BITS'(dl.rad) : nxw + WIDE_BITS'(dl.rad);
        else if (dl.hit)
        begin
            nxw = dl.sx ? nxw - WIDE_BITS'(dl.qx) : nxw + WIDE_BITS'(dl.qx);
            nyw = dl.sy ? nyw - WIDE_BITS'(dl.qy) : nyw + WIDE_BITS'(dl.qy);
        end
        out_next.bx = sat_coord(nxw);
        out_next.by = sat_coord(nyw);
        out_next.nv = dl.hit ? dl.nv : dl.vx;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_reg.vld <= 1'b0;
        else if (en)
            out_reg <= out_next;
    end

    assign out_valid = out_reg.vld;
    assign hit       = out_reg.hit;
    assign new_x     = out_reg.bx;
    assign new_y     = out_reg.by;
    assign new_vx    = out_reg.nv;

    // a waiting result holds while the receiver stalls
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(new_x) && $stable(hit))
        else $error("result changed while stalled");

    // the row only moves when the output can take a result
    assert property (@(posedge clk) disable iff (!rst_n)
        in_ready == (!out_valid || out_ready))
        else $error("input ready out of step with output");

    // a miss passes the ball speed through
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !hit |-> new_vx == out_reg.vx)
        else $error("miss changed speed");

endmodule

// File: sim/tb_top.sv
// testbench for the circle-box collision response block
`timescale 1ns / 1ps
module tb_top;
    import cbcr_pkg::*;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic signed [COORD_BITS-1:0] ball_x = '0, ball_y = '0, ball_vx = '0;
    logic signed [COORD_BITS-1:0] box_cx = '0, box_cy = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic hit;
    logic signed [COORD_BITS-1:0] new_x, new_y, new_vx;
    logic cfg_we = 1'b0;
    logic [IDX_BITS-1:0] cfg_idx = '0;
    logic [CFG_BITS-1:0] cfg_data = '0;

    typedef struct packed {
        logic hit;
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [15:0] vx;
    } response_t;

    response_t pending_q[$];
    int errors = 0;
    int n_sent = 0;
    int n_checked = 0;
    int n_hits = 0;
    bit long_stall = 1'b0;
    bit burst_mode = 1'b1;

    // local copy of the registers
    longint rad_r = 320, wid_r = 480, hgt_r = 2400, gain_r = 269;

    always #5 clk = ~clk;

    circle_box_collision_response dut (.*);

    function automatic longint unsigned root_floor(longint unsigned v);
        longint unsigned r, t;
        r = 0;
        for (int b = 31; b >= 0; b--)
        begin
            t = r | (64'd1 << b);
            if (t * t <= v)
                r = t;
        end
        return r;
    endfunction

    function automatic logic signed [15:0] clip16(longint v);
        if (v > 32767)
            return 16'sd32767;
        if (v < -32768)
            return -16'sd32768;
        return v[15:0];
    endfunction

    // expected collision response for one query
    function automatic response_t resolve_collision(longint bx, longint by, longint vx,
                                                    longint cx, longint cy);
        response_t res;
        longint left, top, dx, dy, nx, ny, px, py, vm;
        longint unsigned adx, ady, dsq, root_d, ovl;
        left = cx - (wid_r >> 1);
        top = cy - (hgt_r >> 1);
        dx = bx - ((bx < left) ? left : (bx > left + wid_r) ? left + wid_r : bx);
        dy = by - ((by < top) ? top : (by > top + hgt_r) ? top + hgt_r : by);
        adx = (dx < 0) ? -dx : dx;
        ady = (dy < 0) ? -dy : dy;
        res = '{1'b0, bx[15:0], by[15:0], vx[15:0]};
        if (adx >= rad_r || ady >= rad_r)
            return res;
        dsq = adx * adx + ady * ady;
        if (dsq >= rad_r * rad_r)
            return res;
        nx = bx;
        ny = by;
        if (dsq > 0)
        begin
            root_d = root_floor(dsq);
            ovl = rad_r - root_d;
            px = (adx * ovl) / root_d;
            py = (ady * ovl) / root_d;
            nx = bx + ((dx < 0) ? -px : px);
            ny = by + ((dy < 0) ? -py : py);
        end
        else
            nx = bx + ((vx > 0) ? -rad_r : rad_r);
        vm = (((vx < 0) ? -vx : vx) * gain_r) >>> 8;
        res.hit = 1'b1;
        res.x = clip16(nx);
        res.y = clip16(ny);
        res.vx = clip16((vx > 0) ? -vm : vm);
        return res;
    endfunction

    // one register write, block idle
    task automatic write_reg(reg_idx_t idx, int value);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_idx <= idx;
        cfg_data <= value[CFG_BITS-1:0];
        @(negedge clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_RADIUS: rad_r = value & 16'h3FFF;
            REG_WIDTH:  wid_r = value & 16'h3FFF;
            REG_HEIGHT: hgt_r = value & 16'h3FFF;
            default:    gain_r = value & 9'h1FF;
        endcase
    endtask

    // send one query and hold it until the transfer
    task automatic send_query(int bx, int by, int vx, int cx, int cy);
        response_t exp_r;
        in_valid <= 1'b1;
        ball_x <= bx[15:0];
        ball_y <= by[15:0];
        ball_vx <= vx[15:0];
        box_cx <= cx[15:0];
        box_cy <= cy[15:0];
        exp_r = resolve_collision(longint'(16'(bx)) <<< 48 >>> 48,
                                  longint'(16'(by)) <<< 48 >>> 48,
                                  longint'(16'(vx)) <<< 48 >>> 48,
                                  longint'(16'(cx)) <<< 48 >>> 48,
                                  longint'(16'(cy)) <<< 48 >>> 48);
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        pending_q.push_back(exp_r);
        n_sent++;
        @(negedge clk);
        if (burst_mode && $urandom_range(0, 5) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clk);
        end
    endtask

    task automatic finish_sending();
        in_valid <= 1'b0;
    endtask

    // wait until all responses are back, then let the pipe drain
    task automatic drain();
        int guard;
        guard = 0;
        finish_sending();
        while (pending_q.size() != 0 && guard < 200000)
        begin
            @(negedge clk);
            guard++;
        end
        repeat (40) @(negedge clk);
    endtask

    // random query near the box, mostly close enough to hit
    task automatic send_near(int spread);
        int cx, cy;
        cx = $urandom_range(0, 65535) - 32768;
        cy = $urandom_range(0, 65535) - 32768;
        send_query(cx + $urandom_range(0, 2 * spread) - spread,
                   cy + $urandom_range(0, 2 * spread) - spread,
                   $urandom_range(0, 65535) - 32768, cx, cy);
    endtask

    task automatic test_directed();
        send_query(0, 0, 100, 0, 0);
        send_query(0, 0, -100, 0, 0);
        send_query(0, 0, 0, 0, 0);
        send_query(32767, 32767, 32767, 32767, 32767);
        send_query(-32768, -32768, -32768, -32768, -32768);
        send_query(32767, 0, -32768, 32767, 0);
        send_query(-32768, 0, 32767, -32768, 0);
        send_query(250, 0, 50, 0, 0);
        send_query(-250, 1210, -50, 0, 0);
        send_query(600, 0, 50, 0, 0);
        send_query(259, 0, 50, 0, 0);
        send_query(260, 1220, 50, 0, 0);
        send_query(32767, -32768, 1, 0, 0);
        drain();
        write_reg(REG_RADIUS, 0);
        send_query(0, 0, 10, 0, 0);
        send_query(241, 0, 10, 0, 0);
        drain();
        write_reg(REG_RADIUS, 16383);
        write_reg(REG_WIDTH, 0);
        write_reg(REG_HEIGHT, 0);
        write_reg(REG_GAIN, 511);
        send_query(0, 0, 32767, 0, 0);
        send_query(100, 100, -32768, 0, 0);
        send_query(32767, 32767, 5, -32768, -32768);
        send_query(-16000, 16000, -5, 0, 0);
        drain();
        write_reg(REG_WIDTH, 16383);
        write_reg(REG_HEIGHT, 16383);
        write_reg(REG_GAIN, 256);
        send_query(32767, -32768, 77, 0, 0);
        send_query(-32768, 32767, -77, 32767, -32768);
        drain();
    endtask

    task automatic test_random_settings(int phases, int per_phase);
        for (int p = 0; p < phases; p++)
        begin
            write_reg(REG_RADIUS, $urandom_range(0, 3) == 0 ?
                      $urandom_range(0, 16383) : $urandom_range(1, 1024));
            write_reg(REG_WIDTH, $urandom_range(0, 3) == 0 ?
                      $urandom_range(0, 16383) : $urandom_range(0, 2048));
            write_reg(REG_HEIGHT, $urandom_range(0, 3) == 0 ?
                      $urandom_range(0, 16383) : $urandom_range(0, 4096));
            write_reg(REG_GAIN, $urandom_range(0, 3) == 0 ?
                      $urandom_range(0, 255) : $urandom_range(256, 511));
            burst_mode = (p % 3 != 2);
            for (int i = 0; i < per_phase; i++)
            begin
                if ($urandom_range(0, 9) < 8)
                    send_near(int'(rad_r) + int'(hgt_r) / 2 + 64);
                else
                    send_query($urandom_range(0, 65535) - 32768,
                               $urandom_range(0, 65535) - 32768,
                               $urandom_range(0, 65535) - 32768,
                               $urandom_range(0, 65535) - 32768,
                               $urandom_range(0, 65535) - 32768);
            end
            drain();
        end
        burst_mode = 1'b1;
    endtask

    // receiver holds off long enough to back up the whole pipe
    task automatic test_backpressure();
        long_stall = 1'b1;
        for (int i = 0; i < 80; i++)
            send_near(int'(rad_r) + 64);
        drain();
    endtask

    // receiver stall pattern, with a long hold-off on request
    initial
    begin
        int cnt;
        cnt = 0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (long_stall)
            begin
                out_ready <= 1'b0;
                repeat (150) @(negedge clk);
                long_stall = 1'b0;
            end
            cnt++;
            if ((cnt / 200) % 2 == 1)
                out_ready <= 1'b1;
            else
                out_ready <= ($urandom_range(0, 3) != 0) && (cnt % 7 != 3);
        end
    end

    // result checker
    always @(posedge clk)
    begin
        response_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_q.size() == 0)
            begin
                $display("%0t: unexpected result hit=%0b x=%0d y=%0d vx=%0d",
                         $time, hit, new_x, new_y, new_vx);
                errors++;
            end
            else
            begin
                want = pending_q.pop_front();
                n_checked++;
                if (want.hit)
                    n_hits++;
                if (hit !== want.hit)
                begin
                    $display("%0t: hit expected %0b actual %0b", $time, want.hit, hit);
                    errors++;
                end
                if (new_x !== want.x)
                begin
                    $display("%0t: new_x expected %0d actual %0d", $time, want.x, new_x);
                    errors++;
                end
                if (new_y !== want.y)
                begin
                    $display("%0t: new_y expected %0d actual %0d", $time, want.y, new_y);
                    errors++;
                end
                if (new_vx !== want.vx)
                begin
                    $display("%0t: new_vx expected %0d actual %0d",
                             $time, want.vx, new_vx);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        #20ms;
        $display("timeout with %0d results outstanding", pending_q.size());
        $display("Regression FAIL");
        $finish;
    end

    initial
    begin
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        test_directed();
        test_backpressure();
        test_random_settings(12, 150);
        $display("sent %0d queries, checked %0d responses, %0d hits",
                 n_sent, n_checked, n_hits);
        $display("covered register extremes, pipe backpressure and random geometry");
        if (errors == 0 && pending_q.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
